>>> rtl/assert_macros.svh
// Assertion helpers used by the parser back module (lpdp_back).
// Each helper checks one property on the rising clock edge, with checking
// switched off while the reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication: when ante holds, cons must hold too.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> rtl/lpdp_pkg.sv
package lpdp_pkg;

  // Character codes that steer the parser.
  localparam logic [7:0] ASCII_MINUS  = 8'h2D;
  localparam logic [7:0] ASCII_DOT    = 8'h2E;
  localparam logic [7:0] ASCII_DOLLAR = 8'h24;
  localparam logic [7:0] ASCII_ZERO   = 8'h30;
  localparam logic [7:0] ASCII_NINE   = 8'h39;

  // At most this many fraction digits take part in the value.
  localparam logic [2:0] MAX_FRAC_DIGITS = 3'd4;

  // Default depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH_DEF = 4;

  typedef struct packed {
    logic       frame_start;
    logic [7:0] char_byte;
  } item_t;

  typedef struct packed {
    logic        not_a_number;
    logic        negative;
    logic [15:0] int_part;
    logic [15:0] frac_q16;
    logic [2:0]  frac_digits;
  } result_t;

  // Byte classes found by the front.
  typedef enum logic [2:0] {
    CLS_START,
    CLS_DOLLAR,
    CLS_MINUS,
    CLS_DOT,
    CLS_OTHER
  } char_class_t;

  // One classified byte as it waits in the queue.
  typedef struct packed {
    char_class_t kind;
    logic [7:0]  char_byte;
    logic [3:0]  frac_digit;
  } entry_t;

  // Divisor for a fraction of n digits.
  function automatic logic [13:0] pow_ten(input logic [2:0] n);
    logic [13:0] p;
    case (n)
      3'd0:    p = 14'd1;
      3'd1:    p = 14'd10;
      3'd2:    p = 14'd100;
      3'd3:    p = 14'd1000;
      default: p = 14'd10000;
    endcase
    return p;
  endfunction

endpackage

>>> rtl/lpdp_front.sv
module lpdp_front import lpdp_pkg::*; (
  input  logic   item_valid,
  input  item_t  item,
  output logic   item_stall,
  input  logic   queue_full,
  output logic   push,
  output entry_t entry
);

  logic is_digit;

  assign item_stall = queue_full;
  assign push       = item_valid && !queue_full;
  assign is_digit   = (item.char_byte >= ASCII_ZERO) && (item.char_byte <= ASCII_NINE);

  always_comb begin
    entry.char_byte  = item.char_byte;
    entry.frac_digit = is_digit ? 4'(item.char_byte - ASCII_ZERO) : 4'd0;
    priority if (item.frame_start) begin
      entry.kind = CLS_START;
    end else if (item.char_byte == ASCII_DOLLAR) begin
      entry.kind = CLS_DOLLAR;
    end else if (item.char_byte == ASCII_MINUS) begin
      entry.kind = CLS_MINUS;
    end else if (item.char_byte == ASCII_DOT) begin
      entry.kind = CLS_DOT;
    end else begin
      entry.kind = CLS_OTHER;
    end
  end

endmodule

>>> rtl/lpdp_queue.sv
module lpdp_queue import lpdp_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t wdata,
  input  logic   pop,
  output entry_t rdata,
  output logic   full,
  output logic   empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             storage [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign rdata = storage[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      storage[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/lpdp_div.sv
module lpdp_div import lpdp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [13:0] frac,
  input  logic [2:0]  digits,
  output logic        done,
  output logic [15:0] quotient
);

  // Forms floor(frac * 2^16 / 10^digits) as frac times a rounded-up reciprocal
  // of 10^digits, followed by a right shift. Each reciprocal is sized so the
  // rounding error stays below one unit for every fraction below its divisor.
  // The operands are latched on start and the quotient is registered in the
  // following cycle, when done pulses.
  logic        busy;
  logic [13:0] frac_q;
  logic [2:0]  digits_q;
  logic [29:0] recip;
  logic [43:0] product;
  logic [15:0] scaled;

  always_comb begin
    unique case (digits_q)
      3'd1:    recip = 30'd838861;
      3'd2:    recip = 30'd10737419;
      3'd3:    recip = 30'd68719477;
      default: recip = 30'd879609303;
    endcase
  end

  assign product = {30'd0, frac_q} * {14'd0, recip};

  always_comb begin
    unique case (digits_q)
      3'd1:    scaled = product[22:7];
      3'd2:    scaled = product[29:14];
      3'd3:    scaled = product[35:20];
      default: scaled = product[42:27];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        frac_q   <= frac;
        digits_q <= digits;
      end else if (busy) begin
        busy     <= 1'b0;
        done     <= 1'b1;
        quotient <= scaled;
      end
    end
  end

endmodule

>>> rtl/lpdp_back.sv
`include "assert_macros.svh"

module lpdp_back import lpdp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        queue_empty,
  input  entry_t      ent,
  output logic        pop,
  output logic        div_start,
  output logic [13:0] div_frac,
  output logic [2:0]  div_digits,
  input  logic        div_done,
  input  logic [15:0] div_quot,
  output logic        result_valid,
  output result_t     result,
  input  logic        result_stall
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LEN,
    PH_FIRST,
    PH_INT,
    PH_FRAC
  } phase_t;

  typedef enum logic {
    S_RUN,
    S_DIV
  } state_t;

  state_t      state;
  phase_t      phase, phase_next;
  logic [7:0]  frame_length, frame_length_next;
  logic [7:0]  chars_seen, chars_seen_next;
  logic [15:0] int_accum, int_accum_next;
  logic [13:0] frac_accum, frac_accum_next;
  logic [2:0]  frac_count, frac_count_next;
  logic        sign_flag, sign_flag_next;
  logic        emit_nan;
  logic        emit_num;
  logic [15:0] int_step;
  logic [13:0] frac_step;
  logic [7:0]  seen_inc;
  logic        load_result;
  logic        nan_clear;

  assign pop = !queue_empty && (state == S_RUN) && (!result_valid || !result_stall);

  assign int_step  = (int_accum << 3) + (int_accum << 1) + {8'd0, ent.char_byte}
                     - {8'd0, ASCII_ZERO};
  assign frac_step = (frac_accum << 3) + (frac_accum << 1) + {10'd0, ent.frac_digit};
  assign seen_inc  = chars_seen + 8'd1;

  always_comb begin
    phase_next        = phase;
    frame_length_next = frame_length;
    chars_seen_next   = chars_seen;
    int_accum_next    = int_accum;
    frac_accum_next   = frac_accum;
    frac_count_next   = frac_count;
    sign_flag_next    = sign_flag;
    emit_nan          = 1'b0;
    emit_num          = 1'b0;
    if (ent.kind == CLS_START) begin
      phase_next        = PH_LEN;
      frame_length_next = '0;
      chars_seen_next   = '0;
      int_accum_next    = '0;
      frac_accum_next   = '0;
      frac_count_next   = '0;
      sign_flag_next    = 1'b0;
    end else begin
      unique case (phase)
        PH_IDLE: begin
        end
        PH_LEN: begin
          frame_length_next = ent.char_byte;
          if (ent.char_byte == 8'd0) begin
            emit_nan   = 1'b1;
            phase_next = PH_IDLE;
          end else begin
            phase_next = PH_FIRST;
          end
        end
        PH_FIRST, PH_INT, PH_FRAC: begin
          if (ent.kind == CLS_DOLLAR) begin
            emit_num   = 1'b1;
            phase_next = PH_IDLE;
          end else begin
            priority if (phase == PH_FIRST && ent.kind == CLS_MINUS) begin
              sign_flag_next = 1'b1;
              phase_next     = PH_INT;
            end else if (phase != PH_FRAC && ent.kind == CLS_DOT) begin
              phase_next = PH_FRAC;
            end else if (phase != PH_FRAC) begin
              int_accum_next = int_step;
              phase_next     = PH_INT;
            end else if (frac_count < MAX_FRAC_DIGITS) begin
              frac_accum_next = frac_step;
              frac_count_next = frac_count + 3'd1;
            end else begin
            end
            chars_seen_next = seen_inc;
            if (seen_inc >= frame_length) begin
              emit_num   = 1'b1;
              phase_next = PH_IDLE;
            end
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  assign div_start  = pop && emit_num && (frac_count_next != 3'd0);
  assign div_frac   = frac_accum_next;
  assign div_digits = frac_count_next;

  // A result is loaded either straight from a popped byte or when the
  // fraction scaling finishes.
  assign load_result = (pop && (emit_nan || (emit_num && frac_count_next == 3'd0)))
                       || ((state == S_DIV) && div_done);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_RUN;
      phase        <= PH_IDLE;
      frame_length <= '0;
      chars_seen   <= '0;
      int_accum    <= '0;
      frac_accum   <= '0;
      frac_count   <= '0;
      sign_flag    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (load_result) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_RUN: begin
          if (pop) begin
            phase        <= phase_next;
            frame_length <= frame_length_next;
            chars_seen   <= chars_seen_next;
            int_accum    <= int_accum_next;
            frac_accum   <= frac_accum_next;
            frac_count   <= frac_count_next;
            sign_flag    <= sign_flag_next;
            if (emit_nan) begin
              result.not_a_number <= 1'b1;
              result.negative     <= 1'b0;
              result.int_part     <= '0;
              result.frac_q16     <= '0;
              result.frac_digits  <= '0;
            end else if (emit_num) begin
              result.not_a_number <= 1'b0;
              result.negative     <= sign_flag_next;
              result.int_part     <= int_accum_next;
              result.frac_q16     <= '0;
              result.frac_digits  <= frac_count_next;
              if (frac_count_next != 3'd0) begin
                state <= S_DIV;
              end
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            result.frac_q16 <= div_quot;
            state           <= S_RUN;
          end
        end
        default: state <= S_RUN;
      endcase
    end
  end

  assign nan_clear = !result.negative && (result.int_part == 16'd0) &&
                     (result.frac_digits == 3'd0) && (result.frac_q16 == 16'd0);

  `ASSERT_IMPLIES(a_done_in_div, clk, rst, div_done, state == S_DIV)
  `ASSERT_IMPLIES(a_done_out_free, clk, rst, div_done, !result_valid)
  `ASSERT_NEXT(a_start_enters_div, clk, rst, div_start, state == S_DIV && !result_valid)
  `ASSERT_IMPLIES(a_nan_clean, clk, rst, result_valid && result.not_a_number, nan_clear)
  `ASSERT_IMPLIES(a_frac_cap, clk, rst, 1'b1, frac_count <= MAX_FRAC_DIGITS)

endmodule

>>> rtl/length_prefixed_decimal_parser.sv
// Channel  | Handshake                   | Payload                        | Direction
// item     | item_valid / item_stall     | item_t   (frame_start, byte)   | into block
// result   | result_valid / result_stall | result_t (sign, Q16.16, flags) | out of block
//
// When the back takes the last byte of a number, result_valid rises at that edge, or,
// when fraction digits go through the reciprocal scaling, once the divider is done.
// item_stall is high only while the queue of QUEUE_DEPTH entries is full. The back takes
// one queued byte per cycle, but none while a result waits under result_stall or while
// a fraction is being scaled. Reset is synchronous and active high; it empties the
// queue, idles the parser, cancels any scaling in flight and drops a pending result.
module length_prefixed_decimal_parser import lpdp_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  // Classified bytes travel from the front through the queue to the back.
  logic        push;
  entry_t      push_entry;
  logic        queue_full;
  logic        queue_empty;
  logic        pop;
  entry_t      head_entry;

  // Fraction scaling requests from the back to the divider.
  logic        div_start;
  logic [13:0] div_frac;
  logic [2:0]  div_digits;
  logic        div_done;
  logic [15:0] div_quot;

  // The front sorts each byte into start marker, terminator, minus, dot or
  // other, and precomputes the fraction digit value of the byte.
  lpdp_front u_front (
    .item_valid (item_valid),
    .item       (item),
    .item_stall (item_stall),
    .queue_full (queue_full),
    .push       (push),
    .entry      (push_entry)
  );

  // The queue decouples input acceptance from parsing and the fraction scaling.
  lpdp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (push_entry),
    .pop   (pop),
    .rdata (head_entry),
    .full  (queue_full),
    .empty (queue_empty)
  );

  // The back keeps the frame state, accumulates digits and owns the output
  // register.
  lpdp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .queue_empty  (queue_empty),
    .ent          (head_entry),
    .pop          (pop),
    .div_start    (div_start),
    .div_frac     (div_frac),
    .div_digits   (div_digits),
    .div_done     (div_done),
    .div_quot     (div_quot),
    .result_valid (result_valid),
    .result       (result),
    .result_stall (result_stall)
  );

  // The divider turns the decimal fraction into the low half of Q16.16.
  lpdp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .frac     (div_frac),
    .digits   (div_digits),
    .done     (div_done),
    .quotient (div_quot)
  );

endmodule
